// ===== design/keyed_order_queue_unit_macros.svh =====
// assertion macros for the keyed order queue unit
`ifndef KEYED_ORDER_QUEUE_UNIT_MACROS_SVH
`define KEYED_ORDER_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while in reset
`define KOUQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed order queue check failed");

// next-cycle implication, disabled while in reset
`define KOUQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed order queue check failed");

`else

`define KOUQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KOUQ_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/kouq_pkg.sv =====
// shared types, constants and helpers of the keyed order queue
package kouq_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int KEY_FIELD_W = 32;
    localparam int OCC_FIELD_W = 5;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_POP    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic append;
        logic pop;
        logic remove;
    } cell_ctrl_t;

    // bring the 32-bit key field to the stored key width
    function automatic key_t key_from_field(input logic [KEY_FIELD_W-1:0] f);
        logic [63:0] tmp;
        tmp = 64'(f);
        return tmp[KEY_WIDTH-1:0];
    endfunction

    // bring a stored key back to the 32-bit key field
    function automatic logic [KEY_FIELD_W-1:0] key_to_field(input key_t k);
        logic [63:0] tmp;
        tmp = 64'(k);
        return tmp[KEY_FIELD_W-1:0];
    endfunction

    function automatic logic [OCC_FIELD_W-1:0] occ_to_field(input cnt_t c);
        logic [15:0] tmp;
        tmp = 16'(c);
        return tmp[OCC_FIELD_W-1:0];
    endfunction

endpackage

// ===== design/kouq_cell.sv =====
// one queue slot: holds a key, compares it and shifts from its right neighbor
module kouq_cell (
    input  logic                  clk,
    input  kouq_pkg::cell_ctrl_t  ctrl,
    input  logic [kouq_pkg::IDX_W-1:0] idx,
    input  kouq_pkg::cnt_t        count,
    input  kouq_pkg::key_t        new_key,
    input  kouq_pkg::key_t        right_key,
    input  logic                  seen_in,
    output kouq_pkg::key_t        key,
    output logic                  seen_out
);

    kouq_pkg::key_t key_reg;
    kouq_pkg::key_t key_next;
    logic           valid;
    logic           hit;

    assign valid    = kouq_pkg::CNT_W'(idx) < count;
    assign hit      = valid && (key_reg == new_key);
    // set from the first matching slot onward: those slots close the gap
    assign seen_out = seen_in | hit;
    assign key      = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.append && (kouq_pkg::CNT_W'(idx) == count))
        begin
            key_next = new_key;
        end
        else if ((ctrl.pop && valid) || (ctrl.remove && seen_out))
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ===== design/keyed_order_queue_unit.sv =====
// top level of the keyed order queue: cell row, occupancy count and output register
//
// channel  | dir | tdata                         | tuser
// ---------+-----+-------------------------------+--------------
// s_*      | in  | key_in[31:0]                  | action[1:0]
// m_*      | out | key_out[31:0], occupancy[36:32]| status[1:0]
//
// one transfer per cycle in each direction while the receiver is not stalling; a result
// appears in the cycle after its input transfer, from the output register and the
// single occupancy register. the match chain runs through all DEPTH cells combinationally.
// reset clears the occupancy and the output valid; cell keys stay undefined and
// are never read before written, so there is no clearing pass.
// a stalled result is held in the output register and input is taken again as
// soon as that register is being emptied in the same cycle.
`include "keyed_order_queue_unit_macros.svh"

module keyed_order_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // key_in[31:0]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // key_out[31:0], occupancy[36:32], zero[39:37]
    output logic [1:0]  m_tuser    // status[1:0]
);

    // occupancy and output control
    kouq_pkg::cnt_t    cnt_reg;
    kouq_pkg::cnt_t    cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    // output payload
    logic [31:0]       key_out_reg;
    logic [31:0]       key_out_next;
    kouq_pkg::status_t status_reg;
    kouq_pkg::status_t status_next;

    logic               accept;
    kouq_pkg::action_t  action;
    kouq_pkg::key_t     new_key;
    kouq_pkg::cell_ctrl_t ctrl;
    logic               found;

    // cell row wiring: one extra key slot feeds the last cell's right input
    kouq_pkg::key_t cell_key [kouq_pkg::DEPTH+1];
    logic           seen     [kouq_pkg::DEPTH+1];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign action   = kouq_pkg::action_t'(s_tuser);
    assign new_key  = kouq_pkg::key_from_field(s_tdata);

    assign cell_key[kouq_pkg::DEPTH] = '0;
    assign seen[0]                   = 1'b0;
    assign found                     = seen[kouq_pkg::DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < kouq_pkg::DEPTH; gi++)
        begin : g_cell
            kouq_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .idx       (kouq_pkg::IDX_W'(gi)),
                .count     (cnt_reg),
                .new_key   (new_key),
                .right_key (cell_key[gi+1]),
                .seen_in   (seen[gi]),
                .key       (cell_key[gi]),
                .seen_out  (seen[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        ctrl           = '0;
        cnt_next       = cnt_reg;
        key_out_next   = key_out_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;

        if (accept)
        begin
            out_valid_next = 1'b1;
            unique case (action)
                kouq_pkg::ACT_APPEND:
                begin
                    key_out_next = kouq_pkg::key_to_field(new_key);
                    if (cnt_reg < kouq_pkg::DEPTH_CNT)
                    begin
                        ctrl.append = 1'b1;
                        cnt_next    = cnt_reg + kouq_pkg::CNT_W'(1);
                        status_next = kouq_pkg::ST_DONE;
                    end
                    else
                    begin
                        status_next = kouq_pkg::ST_FULL;
                    end
                end
                kouq_pkg::ACT_POP:
                begin
                    if (cnt_reg == '0)
                    begin
                        key_out_next = '0;
                        status_next  = kouq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        key_out_next = kouq_pkg::key_to_field(cell_key[0]);
                        ctrl.pop     = 1'b1;
                        cnt_next     = cnt_reg - kouq_pkg::CNT_W'(1);
                        status_next  = kouq_pkg::ST_DONE;
                    end
                end
                kouq_pkg::ACT_REMOVE:
                begin
                    // cells from the first match onward shift on their own
                    key_out_next = kouq_pkg::key_to_field(new_key);
                    ctrl.remove  = 1'b1;
                    if (found)
                    begin
                        cnt_next    = cnt_reg - kouq_pkg::CNT_W'(1);
                        status_next = kouq_pkg::ST_DONE;
                    end
                    else
                    begin
                        status_next = kouq_pkg::ST_NOT_FOUND;
                    end
                end
                kouq_pkg::ACT_NOP:
                begin
                    key_out_next = '0;
                    status_next  = kouq_pkg::ST_DONE;
                end
                default:
                begin
                    key_out_next = '0;
                    status_next  = kouq_pkg::ST_DONE;
                end
            endcase
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_out_reg <= key_out_next;
        status_reg  <= status_next;
    end

    // occupancy of the held result equals the current count: both move on the same transfer
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, kouq_pkg::occ_to_field(cnt_reg), key_out_reg};
    assign m_tuser  = status_reg;

    `KOUQ_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= kouq_pkg::DEPTH_CNT)
    `KOUQ_ASSERT_IMP(a_no_take_on_stall, clk, rst_n, m_tvalid && !m_tready, !s_tready)
    `KOUQ_ASSERT_IMP(a_full_status, clk, rst_n,
        m_tvalid && (status_reg == kouq_pkg::ST_FULL), cnt_reg == kouq_pkg::DEPTH_CNT)
    `KOUQ_ASSERT_IMP(a_empty_status, clk, rst_n,
        m_tvalid && (status_reg == kouq_pkg::ST_EMPTY), cnt_reg == '0)
    `KOUQ_ASSERT_NXT(a_pop_dec, clk, rst_n,
        accept && (action == kouq_pkg::ACT_POP) && (cnt_reg != '0),
        cnt_reg == $past(cnt_reg) - kouq_pkg::CNT_W'(1))

endmodule

// ===== sim/tb_keyed_order_queue_unit.sv =====
// self-checking testbench for the keyed order queue unit
`timescale 1ns / 1ps

module tb_keyed_order_queue_unit;

    // cycle budget: about 1900 transfers with their idle and stall cycles
    // plus the long receiver hold, taken many times over
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1870;
    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_PCT     = 32;
    localparam int TAIL_CYCLES  = 8;

    // one expected or observed result
    typedef struct packed {
        kouq_pkg::key_t                   key;
        kouq_pkg::status_t                status;
        logic [kouq_pkg::OCC_FIELD_W-1:0] occ;
    } queue_result_t;

    // mirror of the queue contents and the results still owed by the block
    class kouq_scoreboard;
        kouq_pkg::key_t held_keys[$];
        queue_result_t  owed_q[$];
        int             errors;
        int             checked;
        int             status_seen[4];
        int             peak_occ;

        // apply one accepted transfer to the mirror and queue its result
        function void note_input(kouq_pkg::action_t act, kouq_pkg::key_t key);
            queue_result_t res;
            int            hit;
            res.key    = key;
            res.status = kouq_pkg::ST_DONE;
            hit        = -1;
            unique case (act)
                kouq_pkg::ACT_APPEND:
                begin
                    if (held_keys.size() >= kouq_pkg::DEPTH)
                        res.status = kouq_pkg::ST_FULL;
                    else
                        held_keys.push_back(key);
                end
                kouq_pkg::ACT_POP:
                begin
                    if (held_keys.size() == 0)
                    begin
                        res.status = kouq_pkg::ST_EMPTY;
                        res.key    = '0;
                    end
                    else
                        res.key = held_keys.pop_front();
                end
                kouq_pkg::ACT_REMOVE:
                begin
                    // first match counted from the head
                    foreach (held_keys[i])
                        if (hit < 0 && held_keys[i] == key)
                            hit = i;
                    if (hit < 0)
                        res.status = kouq_pkg::ST_NOT_FOUND;
                    else
                        held_keys.delete(hit);
                end
                default: res.key = '0;
            endcase
            res.occ = kouq_pkg::OCC_FIELD_W'(held_keys.size());
            if (held_keys.size() > peak_occ)
                peak_occ = held_keys.size();
            owed_q.push_back(res);
        endfunction

        // compare one accepted result with the oldest owed one
        function void check_result(kouq_pkg::key_t key, kouq_pkg::status_t status,
                                   logic [kouq_pkg::OCC_FIELD_W-1:0] occ);
            queue_result_t want;
            if (owed_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with none owed: key %h status %s occupancy %0d",
                         $time, key, status.name(), occ);
                return;
            end
            want = owed_q.pop_front();
            checked++;
            status_seen[status]++;
            if (want.key !== key)
            begin
                errors++;
                $display("%0t: key_out expected %h actual %h", $time, want.key, key);
            end
            if (want.status !== status)
            begin
                errors++;
                $display("%0t: status expected %s actual %s", $time,
                         want.status.name(), status.name());
            end
            if (want.occ !== occ)
            begin
                errors++;
                $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, occ);
            end
        endfunction

        function int owed();
            return owed_q.size();
        endfunction

        // a key currently held, or a random one when the queue is empty
        function kouq_pkg::key_t pick_held();
            if (held_keys.size() == 0)
                return kouq_pkg::key_t'($urandom);
            return held_keys[$urandom_range(held_keys.size() - 1)];
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // key_in[31:0]
    logic [1:0]  s_tuser;    // action[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // key_out[31:0], occupancy[36:32], zero[39:37]
    logic [1:0]  m_tuser;    // status[1:0]

    kouq_scoreboard sb = new();

    bit             steady;        // no idling on either side while set
    bit             hold_req;      // asks the receiver for a long hold-off
    int             hold_left;
    int             cycle_count;
    kouq_pkg::key_t key_pool[12];

    keyed_order_queue_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // known values on every input from time zero
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
    end

    // receiver: random stalls, a long hold-off on request, none while steady
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (steady)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // result transfers are checked at the edge that takes them
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(kouq_pkg::key_t'(m_tdata[31:0]),
                            kouq_pkg::status_t'(m_tuser), m_tdata[36:32]);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results owed", cycle_count, sb.owed());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // offer one transfer, starting and ending at a falling edge
    task automatic send_item(input kouq_pkg::action_t act, input kouq_pkg::key_t key);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 32'(key);
        s_tuser  <= act;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(act, key);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (sb.owed() != 0)
            @(posedge clk);
    endtask

    // one random transfer; append_pct tilts the queue toward full or empty
    task automatic send_random(input int append_pct);
        int             roll;
        kouq_pkg::key_t key;
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            // noise: any action, any key
            key = ($urandom_range(1) == 0) ? kouq_pkg::key_t'($urandom) : sb.pick_held();
            send_item(kouq_pkg::action_t'($urandom_range(3)), key);
        end
        else if (roll < 8 + append_pct)
        begin
            key = ($urandom_range(9) < 7) ? key_pool[$urandom_range(11)]
                                          : kouq_pkg::key_t'($urandom);
            send_item(kouq_pkg::ACT_APPEND, key);
        end
        else if ($urandom_range(9) < 4)
            send_item(kouq_pkg::ACT_POP, kouq_pkg::key_t'($urandom));
        else
        begin
            key = ($urandom_range(9) < 8) ? sb.pick_held() : key_pool[$urandom_range(11)];
            send_item(kouq_pkg::ACT_REMOVE, key);
        end
    endtask

    initial
    begin
        kouq_pkg::key_t fill_key;
        int             append_pct;

        // small key pool so removes by key find matches and duplicates occur
        foreach (key_pool[i])
            key_pool[i] = kouq_pkg::key_t'($urandom);
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty queue: no-op, pop and remove by key with nothing held
        send_item(kouq_pkg::ACT_NOP, kouq_pkg::key_t'($urandom));
        send_item(kouq_pkg::ACT_POP, '1);
        send_item(kouq_pkg::ACT_REMOVE, '0);
        // single entry taken by pop, then by key match
        send_item(kouq_pkg::ACT_APPEND, '0);
        send_item(kouq_pkg::ACT_POP, '0);
        send_item(kouq_pkg::ACT_APPEND, '1);
        send_item(kouq_pkg::ACT_REMOVE, '1);
        // fill to depth with one duplicated key
        for (int i = 0; i < kouq_pkg::DEPTH; i++)
        begin
            fill_key = (i == 8) ? kouq_pkg::key_t'(32'h5A5A_0002)
                                : kouq_pkg::key_t'(32'h5A5A_0000 + i);
            send_item(kouq_pkg::ACT_APPEND, fill_key);
        end
        // refused when full
        send_item(kouq_pkg::ACT_APPEND, kouq_pkg::key_t'(32'hDEAD_BEEF));
        // tail entry
        send_item(kouq_pkg::ACT_REMOVE, kouq_pkg::key_t'(32'h5A5A_000F));
        // first of the duplicate pair
        send_item(kouq_pkg::ACT_REMOVE, kouq_pkg::key_t'(32'h5A5A_0002));
        // no match
        send_item(kouq_pkg::ACT_REMOVE, kouq_pkg::key_t'(32'h1234_5678));
        send_item(kouq_pkg::ACT_POP, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // alternate filling and draining phases so occupancy sweeps 0..DEPTH
            append_pct = ((n / 120) % 2 == 0) ? 60 : 22;
            steady     = (n >= 700 && n < 1000);
            if (n == 400)
                hold_req = 1'b1;      // sender keeps offering while results back up
            if (n == 1200)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
                @(negedge clk);
            end
            send_random(append_pct);
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("checked %0d results: %0d done, %0d full, %0d empty, %0d not found",
                 sb.checked, sb.status_seen[kouq_pkg::ST_DONE],
                 sb.status_seen[kouq_pkg::ST_FULL], sb.status_seen[kouq_pkg::ST_EMPTY],
                 sb.status_seen[kouq_pkg::ST_NOT_FOUND]);
        $display("peak occupancy %0d of %0d, %0d cycles, %0d mismatches",
                 sb.peak_occ, kouq_pkg::DEPTH, cycle_count, sb.errors);
        if (sb.errors == 0 && sb.owed() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
